// File: rtl/hsv_sweep_to_rgb_unit_defines.svh
// assertion macros used by rtl/hsv_sweep_to_rgb_unit.sv
`ifndef HSV_SWEEP_TO_RGB_UNIT_DEFINES_SVH
`define HSV_SWEEP_TO_RGB_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hsvr_pkg.sv
`timescale 1ns / 1ps

package hsvr_pkg;

    localparam int HUE_W         = 9;
    localparam int FIELD_W       = 7;
    localparam int HUE_MAX       = 360;
    localparam int HUE_RESET     = 291;
    localparam int VAL_RESET     = 100;
    localparam int SECTOR_SPAN   = 60;
    localparam int OFFSET_W      = 6;
    localparam int TOP_VALUE_DEF = 100;
    localparam int SWEEP_W       = HUE_W + 1;

    localparam int ACTION_W   = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HUE_W;
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = ACTION_W + MODE_W;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [ACTION_W-1:0] {
        ACT_STEP    = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_REFRESH = 2'd2
    } action_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_DISPLAY = 2'd0,
        MODE_HUE     = 2'd1,
        MODE_SAT     = 2'd2,
        MODE_BRIGHT  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_STEP    = 2'd0,
        CFG_SAT_STEP    = 2'd1,
        CFG_BRIGHT_STEP = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t               sector;
        logic [OFFSET_W-1:0]   offset;
    } hue_split_t;

    // hue of 360 wraps into the first sector
    function automatic hue_split_t split_hue(input logic [HUE_W-1:0] h);
        hue_split_t res;
        if (h >= HUE_W'(HUE_MAX))
        begin
            res.sector = SEC_0;
            res.offset = OFFSET_W'(h - HUE_W'(HUE_MAX));
        end
        else if (h >= HUE_W'(5 * SECTOR_SPAN))
        begin
            res.sector = SEC_5;
            res.offset = OFFSET_W'(h - HUE_W'(5 * SECTOR_SPAN));
        end
        else if (h >= HUE_W'(4 * SECTOR_SPAN))
        begin
            res.sector = SEC_4;
            res.offset = OFFSET_W'(h - HUE_W'(4 * SECTOR_SPAN));
        end
        else if (h >= HUE_W'(3 * SECTOR_SPAN))
        begin
            res.sector = SEC_3;
            res.offset = OFFSET_W'(h - HUE_W'(3 * SECTOR_SPAN));
        end
        else if (h >= HUE_W'(2 * SECTOR_SPAN))
        begin
            res.sector = SEC_2;
            res.offset = OFFSET_W'(h - HUE_W'(2 * SECTOR_SPAN));
        end
        else if (h >= HUE_W'(SECTOR_SPAN))
        begin
            res.sector = SEC_1;
            res.offset = OFFSET_W'(h - HUE_W'(SECTOR_SPAN));
        end
        else
        begin
            res.sector = SEC_0;
            res.offset = OFFSET_W'(h);
        end
        return res;
    endfunction

endpackage

// File: rtl/hsvr_convert.sv
`timescale 1ns / 1ps

module hsvr_convert #(
    parameter int TOP_VALUE = hsvr_pkg::TOP_VALUE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [hsvr_pkg::HUE_W-1:0]          hue,
    input  logic [$clog2(TOP_VALUE+1)-1:0]      sat,
    input  logic [$clog2(TOP_VALUE+1)-1:0]      bright,
    output logic                                done,
    output logic [$clog2(TOP_VALUE+1)-1:0]      red,
    output logic [$clog2(TOP_VALUE+1)-1:0]      green,
    output logic [$clog2(TOP_VALUE+1)-1:0]      blue
);
    import hsvr_pkg::*;

    localparam int VW     = $clog2(TOP_VALUE + 1);
    localparam int S_TOP  = 2 * VW;
    localparam int S_SPAN = VW + OFFSET_W;
    localparam int MW     = (2 * VW + 1 > VW + OFFSET_W + 1) ? 2 * VW + 1 : VW + OFFSET_W + 1;
    localparam int PW     = 2 * MW;
    // truncated reciprocals, the quotient is at most one short
    localparam int M_TOP  = (1 << S_TOP) / TOP_VALUE;
    localparam int M_SPAN = (1 << S_SPAN) / SECTOR_SPAN;

    typedef enum logic [3:0] {
        C_IDLE,
        C_MX,
        C_MQ,
        C_MR,
        C_VMIN,
        C_MY,
        C_YQ,
        C_YR,
        C_FIN
    } cstate_t;

    cstate_t             state_reg, state_next;
    sector_t             sector_reg, sector_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [VW-1:0]       sat_reg, sat_next;
    logic [VW-1:0]       bright_reg, bright_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [MW-1:0]       x_reg, x_next;
    logic [MW-1:0]       q_reg, q_next;
    logic [MW-1:0]       y_reg, y_next;
    logic [VW-1:0]       vmin_reg, vmin_next;
    logic [VW-1:0]       red_reg, red_next;
    logic [VW-1:0]       green_reg, green_next;
    logic [VW-1:0]       blue_reg, blue_next;
    logic                done_reg, done_next;

    logic [MW-1:0]       mul_a, mul_b;
    logic [MW-1:0]       rem;
    logic [VW-1:0]       a_val, rise, fall;
    hue_split_t          split;

    assign split     = split_hue(hue);
    // the one shared multiplier
    assign prod_next = PW'(mul_a) * PW'(mul_b);

    always_comb
    begin
        state_next  = state_reg;
        sector_next = sector_reg;
        offset_next = offset_reg;
        sat_next    = sat_reg;
        bright_next = bright_reg;
        x_next      = x_reg;
        q_next      = q_reg;
        y_next      = y_reg;
        vmin_next   = vmin_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        done_next   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        rem         = '0;
        a_val       = '0;
        rise        = '0;
        fall        = '0;

        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    sector_next = split.sector;
                    offset_next = split.offset;
                    sat_next    = sat;
                    bright_next = bright;
                    state_next  = C_MX;
                end
            end
            C_MX:
            begin
                mul_a      = MW'(bright_reg);
                mul_b      = MW'(TOP_VALUE) - MW'(sat_reg);
                state_next = C_MQ;
            end
            C_MQ:
            begin
                x_next     = prod_reg[MW-1:0];
                mul_a      = prod_reg[MW-1:0];
                mul_b      = MW'(M_TOP);
                state_next = C_MR;
            end
            C_MR:
            begin
                q_next     = prod_reg[S_TOP +: MW];
                mul_a      = prod_reg[S_TOP +: MW];
                mul_b      = MW'(TOP_VALUE);
                state_next = C_VMIN;
            end
            C_VMIN:
            begin
                rem        = x_reg - prod_reg[MW-1:0];
                vmin_next  = (rem >= MW'(TOP_VALUE)) ? VW'(q_reg + MW'(1)) : VW'(q_reg);
                state_next = C_MY;
            end
            C_MY:
            begin
                mul_a      = MW'(bright_reg) - MW'(vmin_reg);
                mul_b      = MW'(offset_reg);
                state_next = C_YQ;
            end
            C_YQ:
            begin
                y_next     = prod_reg[MW-1:0];
                mul_a      = prod_reg[MW-1:0];
                mul_b      = MW'(M_SPAN);
                state_next = C_YR;
            end
            C_YR:
            begin
                q_next     = prod_reg[S_SPAN +: MW];
                mul_a      = prod_reg[S_SPAN +: MW];
                mul_b      = MW'(SECTOR_SPAN);
                state_next = C_FIN;
            end
            C_FIN:
            begin
                rem   = y_reg - prod_reg[MW-1:0];
                a_val = (rem >= MW'(SECTOR_SPAN)) ? VW'(q_reg + MW'(1)) : VW'(q_reg);
                rise  = vmin_reg + a_val;
                fall  = bright_reg - a_val;
                unique case (sector_reg)
                    SEC_0:
                    begin
                        red_next = bright_reg; green_next = rise; blue_next = vmin_reg;
                    end
                    SEC_1:
                    begin
                        red_next = fall; green_next = bright_reg; blue_next = vmin_reg;
                    end
                    SEC_2:
                    begin
                        red_next = vmin_reg; green_next = bright_reg; blue_next = rise;
                    end
                    SEC_3:
                    begin
                        red_next = vmin_reg; green_next = fall; blue_next = bright_reg;
                    end
                    SEC_4:
                    begin
                        red_next = rise; green_next = vmin_reg; blue_next = bright_reg;
                    end
                    default:
                    begin
                        red_next = bright_reg; green_next = vmin_reg; blue_next = fall;
                    end
                endcase
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= C_IDLE;
            sector_reg <= SEC_0;
            offset_reg <= '0;
            sat_reg    <= '0;
            bright_reg <= '0;
            prod_reg   <= '0;
            x_reg      <= '0;
            q_reg      <= '0;
            y_reg      <= '0;
            vmin_reg   <= '0;
            red_reg    <= '0;
            green_reg  <= '0;
            blue_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sector_reg <= sector_next;
            offset_reg <= offset_next;
            sat_reg    <= sat_next;
            bright_reg <= bright_next;
            prod_reg   <= prod_next;
            x_reg      <= x_next;
            q_reg      <= q_next;
            y_reg      <= y_next;
            vmin_reg   <= vmin_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            done_reg   <= done_next;
        end
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// File: rtl/hsv_sweep_to_rgb_unit.sv
`timescale 1ns / 1ps
`include "hsv_sweep_to_rgb_unit_defines.svh"

// Holds a color as hue (0..360), saturation and brightness (0..TOP_VALUE) with one
// sweep-direction flag. A step item moves the value picked by mode by its configured
// step, clamping at the range ends and turning the flag there; a load item replaces
// and clamps all three; every item returns one result with the HSV-to-RGB duty values
// and the values now held. One item is taken at a time: an accepted item passes the
// update state, eight steps of the conversion sequencer around its single shared
// multiplier, and the move of the finished conversion into the output register,
// and the next item is taken only after that. While the output register still holds
// an unaccepted result, the finished conversion waits and the input stays closed.
// Step registers are written through the cfg port at any time the block is idle;
// the cfg port is always ready.
module hsv_sweep_to_rgb_unit #(
    parameter int TOP_VALUE = hsvr_pkg::TOP_VALUE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // new_hue[8:0], new_sat[15:9], new_bright[22:16], zero fill above
    input  logic [hsvr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // action[1:0], mode[3:2]
    input  logic [hsvr_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // red[6:0], green[13:7], blue[20:14], hue_now[29:21], sat_now[36:30],
    // bright_now[43:37], zero fill above
    output logic [hsvr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hsvr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hsvr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import hsvr_pkg::*;

    localparam int VW = $clog2(TOP_VALUE + 1);
    localparam int VAL_INIT = (VAL_RESET > TOP_VALUE) ? TOP_VALUE : VAL_RESET;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CONV,
        ST_HOLD
    } state_t;

    state_t                state_reg, state_next;
    logic [HUE_W-1:0]      hue_step_reg, hue_step_next;
    logic [FIELD_W-1:0]    sat_step_reg, sat_step_next;
    logic [FIELD_W-1:0]    bright_step_reg, bright_step_next;
    logic [HUE_W-1:0]      hue_value_reg, hue_value_next;
    logic [VW-1:0]         sat_value_reg, sat_value_next;
    logic [VW-1:0]         bright_value_reg, bright_value_next;
    logic                  sweep_up_reg, sweep_up_next;
    logic [ACTION_W-1:0]   action_reg, action_next;
    mode_t                 mode_reg, mode_next;
    logic [HUE_W-1:0]      new_hue_reg, new_hue_next;
    logic [FIELD_W-1:0]    new_sat_reg, new_sat_next;
    logic [FIELD_W-1:0]    new_bright_reg, new_bright_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [SWEEP_W-1:0]    sw_cur, sw_step, sw_hi, sw_sum, sw_res;
    logic                  sw_flip;
    logic                  out_free, out_load;
    logic                  conv_start, conv_done;
    logic [VW-1:0]         conv_red, conv_green, conv_blue;

    // shared sweep adder for whichever value mode picks
    always_comb
    begin
        unique case (mode_reg)
            MODE_HUE:
            begin
                sw_cur  = SWEEP_W'(hue_value_reg);
                sw_step = SWEEP_W'(hue_step_reg);
                sw_hi   = SWEEP_W'(HUE_MAX);
            end
            MODE_SAT:
            begin
                sw_cur  = SWEEP_W'(sat_value_reg);
                sw_step = SWEEP_W'(sat_step_reg);
                sw_hi   = SWEEP_W'(TOP_VALUE);
            end
            MODE_BRIGHT:
            begin
                sw_cur  = SWEEP_W'(bright_value_reg);
                sw_step = SWEEP_W'(bright_step_reg);
                sw_hi   = SWEEP_W'(TOP_VALUE);
            end
            MODE_DISPLAY:
            begin
                sw_cur  = '0;
                sw_step = '0;
                sw_hi   = '0;
            end
        endcase
        sw_sum = sw_cur + sw_step;
        if (sweep_up_reg)
        begin
            sw_flip = (sw_sum >= sw_hi);
            sw_res  = sw_flip ? sw_hi : sw_sum;
        end
        else
        begin
            // no wrap below zero
            sw_flip = (sw_cur <= sw_step);
            sw_res  = sw_flip ? '0 : sw_cur - sw_step;
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        hue_step_next     = hue_step_reg;
        sat_step_next     = sat_step_reg;
        bright_step_next  = bright_step_reg;
        hue_value_next    = hue_value_reg;
        sat_value_next    = sat_value_reg;
        bright_value_next = bright_value_reg;
        sweep_up_next     = sweep_up_reg;
        action_next       = action_reg;
        mode_next         = mode_reg;
        new_hue_next      = new_hue_reg;
        new_sat_next      = new_sat_reg;
        new_bright_next   = new_bright_reg;
        out_data_next     = out_data_reg;
        conv_start        = 1'b0;
        out_load          = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HUE_STEP:    hue_step_next    = cfg_data;
                CFG_SAT_STEP:    sat_step_next    = cfg_data[FIELD_W-1:0];
                CFG_BRIGHT_STEP: bright_step_next = cfg_data[FIELD_W-1:0];
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    action_next     = s_axis_tuser[ACTION_W-1:0];
                    mode_next       = mode_t'(s_axis_tuser[ACTION_W +: MODE_W]);
                    new_hue_next    = s_axis_tdata[HUE_W-1:0];
                    new_sat_next    = s_axis_tdata[HUE_W +: FIELD_W];
                    new_bright_next = s_axis_tdata[HUE_W + FIELD_W +: FIELD_W];
                    state_next      = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                unique case (action_reg)
                    ACT_STEP:
                    begin
                        unique case (mode_reg)
                            MODE_HUE:     hue_value_next    = HUE_W'(sw_res);
                            MODE_SAT:     sat_value_next    = VW'(sw_res);
                            MODE_BRIGHT:  bright_value_next = VW'(sw_res);
                            MODE_DISPLAY: ;
                        endcase
                        if (mode_reg != MODE_DISPLAY && sw_flip)
                        begin
                            sweep_up_next = !sweep_up_reg;
                        end
                    end
                    ACT_LOAD:
                    begin
                        hue_value_next = (new_hue_reg > HUE_W'(HUE_MAX)) ?
                                         HUE_W'(HUE_MAX) : new_hue_reg;
                        sat_value_next = (SWEEP_W'(new_sat_reg) > SWEEP_W'(TOP_VALUE)) ?
                                         VW'(TOP_VALUE) : VW'(new_sat_reg);
                        bright_value_next =
                            (SWEEP_W'(new_bright_reg) > SWEEP_W'(TOP_VALUE)) ?
                            VW'(TOP_VALUE) : VW'(new_bright_reg);
                    end
                    default:
                    begin
                        // refresh and the unused code leave the values alone
                    end
                endcase
                conv_start = 1'b1;
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase

        if (out_load)
        begin
            out_data_next = {4'b0000,
                             FIELD_W'(bright_value_reg),
                             FIELD_W'(sat_value_reg),
                             hue_value_reg,
                             FIELD_W'(conv_blue),
                             FIELD_W'(conv_green),
                             FIELD_W'(conv_red)};
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    hsvr_convert #(
        .TOP_VALUE (TOP_VALUE)
    ) u_convert (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .hue    (hue_value_next),
        .sat    (sat_value_next),
        .bright (bright_value_next),
        .done   (conv_done),
        .red    (conv_red),
        .green  (conv_green),
        .blue   (conv_blue)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            hue_step_reg     <= HUE_W'(1);
            sat_step_reg     <= FIELD_W'(1);
            bright_step_reg  <= FIELD_W'(1);
            hue_value_reg    <= HUE_W'(HUE_RESET);
            sat_value_reg    <= VW'(VAL_INIT);
            bright_value_reg <= VW'(VAL_INIT);
            sweep_up_reg     <= 1'b1;
            action_reg       <= '0;
            mode_reg         <= MODE_DISPLAY;
            new_hue_reg      <= '0;
            new_sat_reg      <= '0;
            new_bright_reg   <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            hue_step_reg     <= hue_step_next;
            sat_step_reg     <= sat_step_next;
            bright_step_reg  <= bright_step_next;
            hue_value_reg    <= hue_value_next;
            sat_value_reg    <= sat_value_next;
            bright_value_reg <= bright_value_next;
            sweep_up_reg     <= sweep_up_next;
            action_reg       <= action_next;
            mode_reg         <= mode_next;
            new_hue_reg      <= new_hue_next;
            new_sat_reg      <= new_sat_next;
            new_bright_reg   <= new_bright_next;
            out_valid_reg    <= out_valid_next;
            out_data_reg     <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `ASSERT_IMPL(a_done_only_in_conv, clk, rst_n, conv_done, state_reg == ST_CONV, "conversion finished while not waiting for it")
    `ASSERT_IMPL(a_values_in_range, clk, rst_n, 1'b1, (hue_value_reg <= HUE_W'(HUE_MAX)) && (SWEEP_W'(sat_value_reg) <= SWEEP_W'(TOP_VALUE)) && (SWEEP_W'(bright_value_reg) <= SWEEP_W'(TOP_VALUE)), "held hsv value out of range")
    `ASSERT_NEXT(a_values_hold_in_conv, clk, rst_n, state_reg == ST_CONV, $stable(hue_value_reg) && $stable(sat_value_reg) && $stable(bright_value_reg) && $stable(sweep_up_reg), "held values changed during conversion")

endmodule

// File: tb/sv/tb_hsv_sweep_to_rgb_unit.sv
`timescale 1ns / 1ps

module tb_hsv_sweep_to_rgb_unit;

    import hsvr_pkg::*;

    localparam int          TOP         = TOP_VALUE_DEF;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          RAND_PHASES = 6;
    localparam int          PHASE_ITEMS = 340;
    localparam int          QUIET_ITEMS = 60;
    // unused action code, the block treats it like a refresh
    localparam logic [1:0]  ACT_SPARE   = 2'd3;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [MODE_W-1:0]   mode;
        logic [HUE_W-1:0]    hue;
        logic [FIELD_W-1:0]  sat;
        logic [FIELD_W-1:0]  bright;
    } hsv_item_t;

    typedef struct {
        int unsigned red;
        int unsigned green;
        int unsigned blue;
        int unsigned hue;
        int unsigned sat;
        int unsigned bright;
    } rgb_result_t;

    class hsv_scoreboard;
        int unsigned hue_inc;
        int unsigned sat_inc;
        int unsigned bright_inc;
        int unsigned hue_val;
        int unsigned sat_val;
        int unsigned bright_val;
        bit          rising;
        rgb_result_t expected_q[$];
        int          errors;

        function new();
            hue_inc    = 1;
            sat_inc    = 1;
            bright_inc = 1;
            hue_val    = HUE_RESET;
            sat_val    = (VAL_RESET > TOP) ? TOP : VAL_RESET;
            bright_val = (VAL_RESET > TOP) ? TOP : VAL_RESET;
            rising     = 1'b1;
            errors     = 0;
        endfunction

        function void set_step(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_HUE_STEP:    hue_inc = 32'(value);
                CFG_SAT_STEP:    sat_inc = 32'(value[FIELD_W-1:0]);
                CFG_BRIGHT_STEP: bright_inc = 32'(value[FIELD_W-1:0]);
                default: ;
            endcase
        endfunction

        // shared direction flag turns at either bound
        function int unsigned sweep(int unsigned cur, int unsigned inc, int unsigned hi);
            int unsigned nxt;
            if (rising)
            begin
                nxt = cur + inc;
                if (nxt >= hi)
                begin
                    nxt = hi;
                    rising = 1'b0;
                end
                return nxt;
            end
            if (cur <= inc)
            begin
                rising = 1'b1;
                return 0;
            end
            return cur - inc;
        endfunction

        function void note_input(hsv_item_t it);
            rgb_result_t res;
            int unsigned sector;
            int unsigned vmin;
            int unsigned a;
            int unsigned rise;
            int unsigned fall;
            int unsigned v;
            if (it.action == ACT_STEP)
            begin
                case (it.mode)
                    MODE_HUE:    hue_val = sweep(hue_val, hue_inc, HUE_MAX);
                    MODE_SAT:    sat_val = sweep(sat_val, sat_inc, TOP);
                    MODE_BRIGHT: bright_val = sweep(bright_val, bright_inc, TOP);
                    default: ;
                endcase
            end
            else if (it.action == ACT_LOAD)
            begin
                hue_val    = (it.hue > HUE_MAX) ? HUE_MAX : 32'(it.hue);
                sat_val    = (it.sat > TOP) ? TOP : 32'(it.sat);
                bright_val = (it.bright > TOP) ? TOP : 32'(it.bright);
            end
            v      = bright_val;
            sector = (hue_val / SECTOR_SPAN) % 6;
            vmin   = (v * (TOP - sat_val)) / TOP;
            a      = ((v - vmin) * (hue_val % SECTOR_SPAN)) / SECTOR_SPAN;
            rise   = vmin + a;
            fall   = v - a;
            case (sector)
                0:
                begin
                    res.red = v;    res.green = rise; res.blue = vmin;
                end
                1:
                begin
                    res.red = fall; res.green = v;    res.blue = vmin;
                end
                2:
                begin
                    res.red = vmin; res.green = v;    res.blue = rise;
                end
                3:
                begin
                    res.red = vmin; res.green = fall; res.blue = v;
                end
                4:
                begin
                    res.red = rise; res.green = vmin; res.blue = v;
                end
                default:
                begin
                    res.red = v;    res.green = vmin; res.blue = fall;
                end
            endcase
            res.red    &= 'h7f;
            res.green  &= 'h7f;
            res.blue   &= 'h7f;
            res.hue    = hue_val & 'h1ff;
            res.sat    = sat_val & 'h7f;
            res.bright = bright_val & 'h7f;
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            rgb_result_t exp;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item pending, expected none, actual %h", $time, d);
                return;
            end
            exp = expected_q.pop_front();
            compare_field("red",        exp.red,    32'(d[6:0]));
            compare_field("green",      exp.green,  32'(d[13:7]));
            compare_field("blue",       exp.blue,   32'(d[20:14]));
            compare_field("hue_now",    exp.hue,    32'(d[29:21]));
            compare_field("sat_now",    exp.sat,    32'(d[36:30]));
            compare_field("bright_now", exp.bright, 32'(d[43:37]));
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic [IN_USER_W-1:0]    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    hsv_scoreboard           color_sb;
    bit                      quiet;
    int                      cycle_count;
    int                      out_stall;

    hsv_sweep_to_rgb_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: check accepted items, then decide tready for the next edge
    initial
    begin
        m_axis_tready = 1'b0;
        out_stall     = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                color_sb.check_result(m_axis_tdata);
            if (out_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                out_stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                out_stall = pick_gap();
            end
        end
    end

    function automatic hsv_item_t make_item(logic [1:0] action, logic [1:0] mode,
                                            int h, int s, int b);
        hsv_item_t it;
        it.action = action;
        it.mode   = mode;
        it.hue    = HUE_W'(h);
        it.sat    = FIELD_W'(s);
        it.bright = FIELD_W'(b);
        return it;
    endfunction

    task automatic send_item(hsv_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.bright, it.sat, it.hue};
        s_axis_tuser  <= {it.mode, it.action};
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        color_sb.note_input(it);
    endtask

    // hold the sender until every expected result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (color_sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_step(cfg_index_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        color_sb.set_step(idx, CFG_DATA_W'(value));
    endtask

    function automatic hsv_item_t random_item();
        hsv_item_t it;
        int r;
        it.mode   = MODE_W'($urandom_range(0, 3));
        it.hue    = HUE_W'($urandom_range(0, 511));
        it.sat    = FIELD_W'($urandom_range(0, 127));
        it.bright = FIELD_W'($urandom_range(0, 127));
        r = $urandom_range(0, 99);
        if (r < 62)
            it.action = ACT_STEP;
        else if (r < 85)
        begin
            it.action = ACT_LOAD;
            // mostly in-range loads, the rest use the whole field
            if ($urandom_range(0, 3) != 0)
            begin
                it.hue    = HUE_W'($urandom_range(0, HUE_MAX));
                it.sat    = FIELD_W'($urandom_range(0, TOP));
                it.bright = FIELD_W'($urandom_range(0, TOP));
            end
        end
        else if (r < 95)
            it.action = ACT_REFRESH;
        else
            it.action = ACT_SPARE;
        return it;
    endfunction

    task automatic run_directed();
        send_item(make_item(ACT_REFRESH, MODE_DISPLAY, 0, 0, 0));
        send_item(make_item(ACT_SPARE, MODE_HUE, 511, 127, 127));
        send_item(make_item(ACT_STEP, MODE_DISPLAY, 0, 0, 0));
        send_item(make_item(ACT_LOAD, MODE_DISPLAY, 0, 0, 0));
        send_item(make_item(ACT_LOAD, MODE_DISPLAY, 511, 127, 127));
        send_item(make_item(ACT_LOAD, MODE_DISPLAY, 360, 100, 100));
        send_item(make_item(ACT_LOAD, MODE_DISPLAY, 59, 100, 100));
        send_item(make_item(ACT_LOAD, MODE_DISPLAY, 60, 50, 100));
        send_item(make_item(ACT_LOAD, MODE_DISPLAY, 150, 73, 91));
        send_item(make_item(ACT_LOAD, MODE_DISPLAY, 210, 100, 37));
        send_item(make_item(ACT_LOAD, MODE_DISPLAY, 270, 1, 100));
        send_item(make_item(ACT_LOAD, MODE_DISPLAY, 330, 99, 1));
        // hue reaches its top and turns, then runs down to zero
        send_item(make_item(ACT_LOAD, MODE_DISPLAY, 359, 100, 100));
        send_item(make_item(ACT_STEP, MODE_HUE, 0, 0, 0));
        send_item(make_item(ACT_STEP, MODE_HUE, 0, 0, 0));
        send_item(make_item(ACT_LOAD, MODE_DISPLAY, 1, 40, 60));
        send_item(make_item(ACT_STEP, MODE_HUE, 0, 0, 0));
        send_item(make_item(ACT_STEP, MODE_SAT, 0, 0, 0));
        send_item(make_item(ACT_STEP, MODE_BRIGHT, 0, 0, 0));
        send_item(make_item(ACT_LOAD, MODE_DISPLAY, 100, 99, 0));
        send_item(make_item(ACT_STEP, MODE_SAT, 0, 0, 0));
        send_item(make_item(ACT_STEP, MODE_SAT, 0, 0, 0));
        send_item(make_item(ACT_STEP, MODE_BRIGHT, 0, 0, 0));
        send_item(make_item(ACT_STEP, MODE_BRIGHT, 0, 0, 0));
    endtask

    // writes go back to back, valid drops after the last one
    task automatic set_steps(int phase);
        case (phase)
            0:
            begin
                write_step(CFG_HUE_STEP, 0);
                write_step(CFG_SAT_STEP, 0);
                write_step(CFG_BRIGHT_STEP, 0);
            end
            1:
            begin
                write_step(CFG_HUE_STEP, HUE_MAX);
                write_step(CFG_SAT_STEP, TOP);
                write_step(CFG_BRIGHT_STEP, TOP);
            end
            2:
            begin
                write_step(CFG_HUE_STEP, 511);
                write_step(CFG_SAT_STEP, 127);
                write_step(CFG_BRIGHT_STEP, 127);
            end
            3:
            begin
                write_step(CFG_HUE_STEP, 1);
                write_step(CFG_SAT_STEP, 1);
                write_step(CFG_BRIGHT_STEP, 1);
            end
            default:
            begin
                write_step(CFG_HUE_STEP, $urandom_range(1, 90));
                write_step(CFG_SAT_STEP, $urandom_range(1, 40));
                write_step(CFG_BRIGHT_STEP, $urandom_range(1, 40));
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        color_sb      = new();
        quiet         = 1'b0;
        cycle_count   = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain();
            set_steps(p);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                quiet = (i < QUIET_ITEMS);
                send_item(random_item());
            end
            quiet = 1'b0;
        end

        drain();
        repeat (30) @(posedge clk);
        if (color_sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hsvr_pkg.sv
rtl/hsvr_convert.sv
rtl/hsv_sweep_to_rgb_unit.sv
tb/sv/tb_hsv_sweep_to_rgb_unit.sv
